// ===== src/pva_pkg.sv =====
// Shared types, widths and codes for the polyphonic voice allocator.
// No dependencies; every other file imports this package.
package pva_pkg;

   localparam int VOICES   = 8;
   localparam int TAG_BITS = 32;

   localparam int OP_W     = 2;
   localparam int NOTE_W   = 7;
   localparam int VEL_W    = 7;
   localparam int STATUS_W = 3;
   localparam int MASK_W   = 8;
   localparam int EN_W     = 4;

   localparam logic [EN_W-1:0] EN_RESET = 4'd8;

   // enabled count compared against voice indexes in this width
   localparam int CNT_W = $clog2(VOICES + 1);
   localparam int CMP_W = (CNT_W > EN_W) ? CNT_W : EN_W;
   // voice vector widened so the result mask can always take its low bits
   localparam int VM_W  = (VOICES > MASK_W) ? VOICES : MASK_W;

   // command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
   localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
   localparam logic [OP_W-1:0] OP_ALL_OFF  = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_FREE         = 3'd0,
      ST_STOLEN       = 3'd1,
      ST_PLAYING      = 3'd2,
      ST_RELEASED     = 3'd3,
      ST_NOT_FOUND    = 3'd4,
      ST_ALL_RELEASED = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CMD_ON,
      CMD_OFF,
      CMD_ALL,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [NOTE_W-1:0]   note;
      logic [VEL_W-1:0]    velocity;
   } cmd_type;

   // keep the low result-mask bits of a voice vector, zero above VOICES
   function automatic logic [MASK_W-1:0] fit_mask(input logic [VOICES-1:0] v);
      logic [VM_W-1:0] wide;
      wide = VM_W'(v);
      return wide[MASK_W-1:0];
   endfunction

endpackage

// ===== src/pva_front.sv =====
// Front end: takes request words and turns them into queue commands.
// Depends on pva_pkg.
module pva_front (
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [pva_pkg::OP_W-1:0]    req_operation,
   input  logic [pva_pkg::NOTE_W-1:0]  req_note_number,
   input  logic [pva_pkg::VEL_W-1:0]   req_note_velocity,
   output logic                        push_valid,
   input  logic                        push_ready,
   output pva_pkg::cmd_type            push_cmd
);
   import pva_pkg::*;

   cmd_kind_type kind;

   always_comb begin
      case (req_operation)
         OP_NOTE_ON: begin
            // velocity zero acts as a release
            kind = (req_note_velocity == '0) ? CMD_OFF : CMD_ON;
         end
         OP_NOTE_OFF: begin
            kind = CMD_OFF;
         end
         OP_ALL_OFF: begin
            kind = CMD_ALL;
         end
         default: begin
            kind = CMD_NOP;
         end
      endcase
   end

   assign push_cmd.kind     = kind;
   assign push_cmd.note     = req_note_number;
   assign push_cmd.velocity = req_note_velocity;
   assign push_valid        = req_valid;
   assign req_ready         = push_ready;

endmodule

// ===== src/pva_fifo.sv =====
// Short command queue between the front end and the voice engine.
// Depends on pva_pkg.
module pva_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  pva_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output pva_pkg::cmd_type pop_cmd
);
   import pva_pkg::*;

   cmd_type             mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != QCNT_W'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/pva_back.sv =====
// Voice engine: holds the voice registers, looks up and executes one command
// in lookup and execute states and drives the result register. Depends on pva_pkg.
module pva_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [pva_pkg::EN_W-1:0]       csr_write_data,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  pva_pkg::cmd_type               pop_cmd,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [pva_pkg::STATUS_W-1:0]   rsp_status,
   output logic [pva_pkg::MASK_W-1:0]     rsp_voice_mask,
   output logic [pva_pkg::NOTE_W-1:0]     rsp_voice_note,
   output logic [pva_pkg::VEL_W-1:0]      rsp_voice_velocity
);
   import pva_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_EXEC
   } state_type;

   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [EN_W-1:0]        enabled_ff, enabled_in;

   logic [VOICES-1:0]      gate_ff, gate_in;
   logic [NOTE_W-1:0]      note_ff [VOICES];
   logic [NOTE_W-1:0]      note_in [VOICES];
   logic [VEL_W-1:0]       vel_ff [VOICES];
   logic [VEL_W-1:0]       vel_in [VOICES];
   logic [TAG_BITS-1:0]    tag_ff [VOICES];
   logic [TAG_BITS-1:0]    tag_in [VOICES];
   logic [TAG_BITS-1:0]    counter_ff, counter_in;

   logic [VOICES-1:0]      win_ff, win_in;
   logic [VOICES-1:0]      first_ff, first_in;
   logic                   any_ff, any_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             status_ff, status_in;
   logic [MASK_W-1:0]      mask_ff, mask_in;
   logic [NOTE_W-1:0]      rnote_ff, rnote_in;
   logic [VEL_W-1:0]       rvel_ff, rvel_in;

   logic [CMP_W-1:0]       active;
   logic [VOICES-1:0]      en;
   logic [VOICES-1:0]      match;
   logic                   out_free;

   // clamp the enabled count to 1..VOICES
   always_comb begin
      if (enabled_ff == '0) begin
         active = CMP_W'(1);
      end else if (CMP_W'(enabled_ff) > CMP_W'(VOICES)) begin
         active = CMP_W'(VOICES);
      end else begin
         active = CMP_W'(enabled_ff);
      end
      for (int i = 0; i < VOICES; i++) begin
         en[i] = (CMP_W'(i) < active);
      end
   end

   // lookup: matching voices, first match, and allocation winner
   always_comb begin
      logic [TAG_BITS:0] key_i, key_j;
      logic              beats;
      for (int i = 0; i < VOICES; i++) begin
         match[i] = en[i] && gate_ff[i] && (note_ff[i] == cmd_ff.note);
      end
      for (int i = 0; i < VOICES; i++) begin
         first_in[i] = match[i] && !(|(match & ((VOICES'(1) << i) - VOICES'(1))));
      end
      for (int i = 0; i < VOICES; i++) begin
         win_in[i] = en[i];
         key_i     = {gate_ff[i], tag_ff[i]};
         for (int j = 0; j < VOICES; j++) begin
            key_j = {gate_ff[j], tag_ff[j]};
            beats = (key_i < key_j) || ((key_i == key_j) && (i < j));
            if (j != i && en[j] && !beats) begin
               win_in[i] = 1'b0;
            end
         end
      end
      any_in = |match;
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (state_ff == S_IDLE) || ((state_ff == S_EXEC) && out_free);

   always_comb begin
      logic [NOTE_W-1:0] hit_note;
      logic [VEL_W-1:0]  hit_vel;
      logic              win_gated;
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      enabled_in   = enabled_ff;
      gate_in      = gate_ff;
      note_in      = note_ff;
      vel_in       = vel_ff;
      tag_in       = tag_ff;
      counter_in   = counter_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      mask_in      = mask_ff;
      rnote_in     = rnote_ff;
      rvel_in      = rvel_ff;
      hit_note     = '0;
      hit_vel      = '0;
      for (int i = 0; i < VOICES; i++) begin
         hit_note = hit_note | (first_ff[i] ? note_ff[i] : '0);
         hit_vel  = hit_vel  | (first_ff[i] ? vel_ff[i] : '0);
      end
      win_gated = |(win_ff & gate_ff);

      if (csr_write_enable) begin
         enabled_in = csr_write_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               cmd_in   = pop_cmd;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               case (cmd_ff.kind)
                  CMD_ON: begin
                     if (any_ff) begin
                        status_in = ST_PLAYING;
                        mask_in   = fit_mask(first_ff);
                        rnote_in  = hit_note;
                        rvel_in   = hit_vel;
                     end else begin
                        status_in  = win_gated ? ST_STOLEN : ST_FREE;
                        mask_in    = fit_mask(win_ff);
                        rnote_in   = cmd_ff.note;
                        rvel_in    = cmd_ff.velocity;
                        counter_in = counter_ff + 1'b1;
                        for (int i = 0; i < VOICES; i++) begin
                           if (win_ff[i]) begin
                              gate_in[i] = 1'b1;
                              note_in[i] = cmd_ff.note;
                              vel_in[i]  = cmd_ff.velocity;
                              tag_in[i]  = counter_ff;
                           end
                        end
                     end
                  end
                  CMD_OFF: begin
                     if (any_ff) begin
                        status_in  = ST_RELEASED;
                        mask_in    = fit_mask(first_ff);
                        rnote_in   = hit_note;
                        rvel_in    = hit_vel;
                        counter_in = counter_ff + 1'b1;
                        for (int i = 0; i < VOICES; i++) begin
                           if (first_ff[i]) begin
                              gate_in[i] = 1'b0;
                              tag_in[i]  = counter_ff;
                           end
                        end
                     end else begin
                        status_in = ST_NOT_FOUND;
                        mask_in   = '0;
                        rnote_in  = '0;
                        rvel_in   = '0;
                     end
                  end
                  CMD_ALL: begin
                     // stamp gated voices in index order
                     status_in  = ST_ALL_RELEASED;
                     mask_in    = fit_mask(gate_ff);
                     rnote_in   = '0;
                     rvel_in    = '0;
                     gate_in    = '0;
                     counter_in = counter_ff + TAG_BITS'($countones(gate_ff));
                     for (int i = 0; i < VOICES; i++) begin
                        if (gate_ff[i]) begin
                           tag_in[i] = counter_ff + TAG_BITS'($countones(
                              gate_ff & ((VOICES'(1) << i) - VOICES'(1))));
                        end
                     end
                  end
                  default: begin
                     status_in = ST_NOT_FOUND;
                     mask_in   = '0;
                     rnote_in  = '0;
                     rvel_in   = '0;
                  end
               endcase
               if (pop_valid) begin
                  cmd_in   = pop_cmd;
                  state_in = S_LOOK;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         enabled_ff   <= EN_RESET;
         gate_ff      <= '0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < VOICES; i++) begin
            note_ff[i] <= '0;
            vel_ff[i]  <= '0;
            tag_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         enabled_ff   <= enabled_in;
         gate_ff      <= gate_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
         note_ff      <= note_in;
         vel_ff       <= vel_in;
         tag_ff       <= tag_in;
      end
      cmd_ff    <= cmd_in;
      status_ff <= status_in;
      mask_ff   <= mask_in;
      rnote_ff  <= rnote_in;
      rvel_ff   <= rvel_in;
      if (state_ff == S_LOOK) begin
         win_ff   <= win_in;
         first_ff <= first_in;
         any_ff   <= any_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_voice_mask     = mask_ff;
   assign rsp_voice_note     = rnote_ff;
   assign rsp_voice_velocity = rvel_ff;

   a_win_onehot: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC |-> $onehot(win_ff))
      else $error("allocation winner is not a single voice");

   a_first_onehot0: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC |-> ($onehot0(first_ff) && (any_ff == (first_ff != '0))))
      else $error("first match vector inconsistent");

   a_counter_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_EXEC |=> $stable(counter_ff))
      else $error("tag counter moved outside execute");

   a_all_off_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && out_free && cmd_ff.kind == CMD_ALL) |=> gate_ff == '0)
      else $error("all notes off left a gated voice");

endmodule

// ===== src/polyphonic_voice_allocator.sv =====
// Polyphonic voice allocator: oldest-voice allocation with stealing.
// Top level; depends on pva_pkg, pva_front, pva_fifo and pva_back.
//
// Usage:
//   req_* carries note events (note on, note off, all notes off) under
//   valid/ready; rsp_* returns exactly one result word per event, in order.
//   csr_write_enable/csr_write_data set the enabled voice count; write it
//   only while no event is in flight.
// Path: a request word passes through the command queue, then the lookup
//   and execute states of the voice engine, into the result register.
// Ordering: one event at a time; the voice engine takes the next event only
//   as execute finishes, since its lookup/execute pair reads and then updates
//   the shared voice registers for each event.
// Reset: all voices free, age tags and the tag counter zero, enabled
//   voice count 8.
// Stall: while a result is held and rsp_ready is low the engine waits in
//   execute; the two-entry command queue keeps taking requests until it
//   fills, then req_ready drops.
module polyphonic_voice_allocator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [pva_pkg::EN_W-1:0]       csr_write_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pva_pkg::OP_W-1:0]       req_operation,
   input  logic [pva_pkg::NOTE_W-1:0]     req_note_number,
   input  logic [pva_pkg::VEL_W-1:0]      req_note_velocity,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [pva_pkg::STATUS_W-1:0]   rsp_status,
   output logic [pva_pkg::MASK_W-1:0]     rsp_voice_mask,
   output logic [pva_pkg::NOTE_W-1:0]     rsp_voice_note,
   output logic [pva_pkg::VEL_W-1:0]      rsp_voice_velocity
);
   import pva_pkg::*;

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   pva_front u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_note_number   (req_note_number),
      .req_note_velocity (req_note_velocity),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_cmd          (push_cmd)
   );

   pva_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   pva_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_cmd            (pop_cmd),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_voice_mask     (rsp_voice_mask),
      .rsp_voice_note     (rsp_voice_note),
      .rsp_voice_velocity (rsp_voice_velocity)
   );

endmodule

// ===== tb/polyphonic_voice_allocator_test.sv =====
`timescale 1ns / 1ps
// Self-checking test for polyphonic_voice_allocator: directed and random note events,
// predicted by a voice-bank tracker class and checked word by word. Needs pva_pkg and the RTL.
module polyphonic_voice_allocator_test;
   import pva_pkg::*;

   localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
   localparam int IDLE_LIMIT    = 4000;
   localparam int LONG_HOLD     = 120;
   localparam int PHASE_EVENTS  = 155;
   localparam int SETTLE_CYCLES = 6;
   localparam int REPORT_MAX    = 10;
   localparam int POOL_SIZE     = 10;
   localparam int SETTINGS_N    = 12;

   typedef struct packed {
      status_type          status;
      logic [MASK_W-1:0]   mask;
      logic [NOTE_W-1:0]   note;
      logic [VEL_W-1:0]    velocity;
   } voice_word_type;

   class voice_bank_tracker;
      logic                gate[VOICES];
      logic [NOTE_W-1:0]   held_note[VOICES];
      logic [VEL_W-1:0]    held_vel[VOICES];
      logic [TAG_BITS-1:0] age[VOICES];
      logic [TAG_BITS-1:0] next_tag;
      logic [EN_W-1:0]     voice_count;
      voice_word_type      awaited[$];
      int                  events;
      int                  words;
      int                  failures;
      int                  status_seen[6];

      function new();
         for (int v = 0; v < VOICES; v++) begin
            gate[v] = 1'b0;
            held_note[v] = '0;
            held_vel[v] = '0;
            age[v] = '0;
         end
         next_tag = '0;
         voice_count = EN_RESET;
         events = 0;
         words = 0;
         failures = 0;
         foreach (status_seen[s]) status_seen[s] = 0;
      endfunction

      function void set_voice_count(logic [EN_W-1:0] value);
         voice_count = value;
      endfunction

      // zero counts as one, anything above the bank saturates
      function int open_voices();
         int n;
         n = voice_count;
         if (n < 1) n = 1;
         if (n > VOICES) n = VOICES;
         return n;
      endfunction

      function void restamp(int v);
         age[v] = next_tag;
         next_tag = next_tag + 1'b1;
      endfunction

      function logic [MASK_W-1:0] voice_bit(int v);
         logic [MASK_W-1:0] m;
         m = '0;
         if (v < MASK_W) m[v] = 1'b1;
         return m;
      endfunction

      function voice_word_type release_one(logic [NOTE_W-1:0] note);
         int n;
         n = open_voices();
         for (int v = 0; v < n; v++) begin
            if (gate[v] && held_note[v] == note) begin
               gate[v] = 1'b0;
               restamp(v);
               return '{status: ST_RELEASED, mask: voice_bit(v), note: held_note[v],
                        velocity: held_vel[v]};
            end
         end
         return '{status: ST_NOT_FOUND, mask: '0, note: '0, velocity: '0};
      endfunction

      function voice_word_type start_note(logic [NOTE_W-1:0] note, logic [VEL_W-1:0] vel);
         int         n;
         int         pick;
         status_type st;
         n = open_voices();
         for (int v = 0; v < n; v++) begin
            if (gate[v] && held_note[v] == note)
               return '{status: ST_PLAYING, mask: voice_bit(v), note: held_note[v],
                        velocity: held_vel[v]};
         end
         // lowest (gate, tag) wins, ties go to the lower voice
         pick = 0;
         for (int v = 1; v < n; v++) begin
            if ((!gate[v] && gate[pick]) || (gate[v] == gate[pick] && age[v] < age[pick]))
               pick = v;
         end
         st = gate[pick] ? ST_STOLEN : ST_FREE;
         held_note[pick] = note;
         held_vel[pick] = vel;
         gate[pick] = 1'b1;
         restamp(pick);
         return '{status: st, mask: voice_bit(pick), note: note, velocity: vel};
      endfunction

      function voice_word_type release_all();
         logic [MASK_W-1:0] m;
         m = '0;
         for (int v = 0; v < VOICES; v++) begin
            if (gate[v]) begin
               gate[v] = 1'b0;
               restamp(v);
               m = m | voice_bit(v);
            end
         end
         return '{status: ST_ALL_RELEASED, mask: m, note: '0, velocity: '0};
      endfunction

      function void take_event(logic [OP_W-1:0] op, logic [NOTE_W-1:0] note,
                               logic [VEL_W-1:0] vel);
         voice_word_type w;
         case (op)
            OP_NOTE_ON: begin
               if (vel == '0) w = release_one(note);
               else w = start_note(note, vel);
            end
            OP_NOTE_OFF: w = release_one(note);
            OP_ALL_OFF: w = release_all();
            default: w = '{status: ST_NOT_FOUND, mask: '0, note: '0, velocity: '0};
         endcase
         awaited.push_back(w);
         events++;
      endfunction

      function void match_word(logic [STATUS_W-1:0] status, logic [MASK_W-1:0] mask,
                               logic [NOTE_W-1:0] note, logic [VEL_W-1:0] vel);
         voice_word_type w;
         if (awaited.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("unexpected result word: status=%0d mask=%h note=%0d vel=%0d",
                        status, mask, note, vel);
            return;
         end
         w = awaited.pop_front();
         words++;
         status_seen[int'(w.status)]++;
         if (status !== w.status || mask !== w.mask || note !== w.note ||
             vel !== w.velocity) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("mismatch on word %0d: expected %s mask=%h note=%0d vel=%0d, ",
                        words, w.status.name(), w.mask, w.note, w.velocity,
                        "got status=%0d mask=%h note=%0d vel=%0d",
                        status, mask, note, vel);
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_write_enable;
   logic [EN_W-1:0]     csr_write_data;
   logic                req_valid;
   logic                req_ready;
   logic [OP_W-1:0]     req_operation;
   logic [NOTE_W-1:0]   req_note_number;
   logic [VEL_W-1:0]    req_note_velocity;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [MASK_W-1:0]   rsp_voice_mask;
   logic [NOTE_W-1:0]   rsp_voice_note;
   logic [VEL_W-1:0]    rsp_voice_velocity;

   voice_bank_tracker   tracker;
   logic [NOTE_W-1:0]   note_pool[POOL_SIZE];
   int                  gap_odds;
   int                  stall_odds;
   bit                  long_hold_due;
   int                  quiet_cycles = 0;

   polyphonic_voice_allocator uut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_note_number    (req_note_number),
      .req_note_velocity  (req_note_velocity),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_voice_mask     (rsp_voice_mask),
      .rsp_voice_note     (rsp_voice_note),
      .rsp_voice_velocity (rsp_voice_velocity)
   );

   always #5 clock = ~clock;

   // end the run when no word moves on either side for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : result_sink
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            tracker.match_word(rsp_status, rsp_voice_mask, rsp_voice_note,
                               rsp_voice_velocity);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (long_hold_due) begin
            // hold off long enough for the queue to fill and req_ready to drop
            long_hold_due = 1'b0;
            hold_left = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            hold_left = $urandom_range(0, 9);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic write_voice_count(logic [EN_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.set_voice_count(value);
   endtask

   task automatic send_event(logic [OP_W-1:0] op, logic [NOTE_W-1:0] note,
                             logic [VEL_W-1:0] vel);
      int gap;
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_note_number <= note;
      req_note_velocity <= vel;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.take_event(op, note, vel);
   endtask

   // drop valid and wait out every outstanding word
   task automatic drain_words();
      req_valid <= 1'b0;
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_random_event();
      int                pick;
      logic [NOTE_W-1:0] note;
      logic [NOTE_W-1:0] any_note;
      logic [VEL_W-1:0]  vel;
      logic [VEL_W-1:0]  any_vel;
      pick = $urandom_range(0, 99);
      note = note_pool[$urandom_range(0, POOL_SIZE - 1)];
      any_note = NOTE_W'($urandom_range(0, 127));
      any_vel = VEL_W'($urandom_range(0, 127));
      vel = VEL_W'($urandom_range(1, 127));
      if ($urandom_range(0, 9) == 0) vel = $urandom_range(0, 1) ? 7'd127 : 7'd1;
      if (pick < 50) send_event(OP_NOTE_ON, note, vel);
      else if (pick < 78) send_event(OP_NOTE_OFF, note, any_vel);
      else if (pick < 86) send_event(OP_NOTE_ON, note, '0);
      else if (pick < 93) send_event(pick[0] ? OP_NOTE_ON : OP_NOTE_OFF, any_note, vel);
      else if (pick < 98) send_event(OP_ALL_OFF, any_note, any_vel);
      else send_event(OP_RESERVED, any_note, any_vel);
   endtask

   initial begin : stimulus
      int counts[SETTINGS_N];
      int base;
      counts = '{8, 1, 0, 15, 2, 5, 3, 7, 4, 6, 9, 8};
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_operation = OP_NOTE_ON;
      req_note_number = '0;
      req_note_velocity = '0;
      gap_odds = 0;
      stall_odds = 0;
      long_hold_due = 1'b0;
      tracker = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_voice_count(EN_RESET);

      send_event(OP_NOTE_ON, 7'd60, 7'd127);
      send_event(OP_NOTE_ON, 7'd60, 7'd5);
      send_event(OP_NOTE_ON, 7'd0, 7'd1);
      send_event(OP_NOTE_ON, 7'd127, 7'd127);
      send_event(OP_NOTE_OFF, 7'd127, 7'd0);
      send_event(OP_NOTE_OFF, 7'd127, 7'd127);
      send_event(OP_NOTE_ON, 7'd0, 7'd0);
      // fill the bank, then steal the oldest voices
      for (int k = 61; k <= 69; k++) send_event(OP_NOTE_ON, NOTE_W'(k), VEL_W'(k - 40));
      send_event(OP_NOTE_ON, 7'd61, 7'd0);
      send_event(OP_ALL_OFF, 7'd0, 7'd0);
      send_event(OP_ALL_OFF, 7'd127, 7'd127);
      send_event(OP_RESERVED, 7'd127, 7'd127);
      send_event(OP_NOTE_OFF, 7'd5, 7'd64);
      send_event(OP_NOTE_ON, 7'd127, 7'd1);
      drain_words();

      for (int p = 0; p < SETTINGS_N; p++) begin
         write_voice_count(EN_W'(counts[p]));
         base = $urandom_range(0, 128 - POOL_SIZE);
         for (int k = 0; k < POOL_SIZE; k++) note_pool[k] = NOTE_W'(base + k);
         if (p % 3 == 0) begin
            note_pool[0] = 7'd0;
            note_pool[POOL_SIZE - 1] = 7'd127;
         end
         if (p == SETTINGS_N - 1) begin
            gap_odds = 0;
            stall_odds = 0;
         end else begin
            gap_odds = $urandom_range(0, 1) ? $urandom_range(3, 8) : 0;
            stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
         end
         if (p == 3) long_hold_due = 1'b1;
         for (int k = 0; k < PHASE_EVENTS; k++) begin
            if (p == 5 && k == PHASE_EVENTS / 2) drain_words();
            send_random_event();
         end
         drain_words();
      end

      $display("Ran %0d note events over %0d voice-count settings (0 and 15 included),",
               tracker.events, SETTINGS_N + 1);
      $display("words: free %0d, stolen %0d, playing %0d, ",
               tracker.status_seen[0], tracker.status_seen[1], tracker.status_seen[2],
               "released %0d, not found %0d, all off %0d",
               tracker.status_seen[3], tracker.status_seen[4], tracker.status_seen[5]);
      if (tracker.awaited.size() != 0) tracker.failures += tracker.awaited.size();
      if (tracker.failures == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
